// ===== src/lt3d_pkg.sv =====
package lt3d_pkg;

    // Fixed field widths
    localparam int IN_W    = 16;   // colour channel, unsigned Q0.16
    localparam int VAL_W   = 18;   // table value / domain min, signed Q1.16
    localparam int RECIP_W = 24;   // reciprocal, unsigned Q8.16
    localparam int IDX_W   = 15;   // linear table index field
    localparam int EDGE_W  = 6;    // lut_edge register
    localparam int OUT_W   = 8;
    localparam int ENTRY_W = 3 * VAL_W;
    localparam int PROD_W  = VAL_W + RECIP_W;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        CFG_EDGE    = 3'd0,
        CFG_MIN_R   = 3'd1,
        CFG_MIN_G   = 3'd2,
        CFG_MIN_B   = 3'd3,
        CFG_RECIP_R = 3'd4,
        CFG_RECIP_G = 3'd5,
        CFG_RECIP_B = 3'd6
    } cfg_idx_t;

    // Table write carried down the pipe to the memory stage
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [ENTRY_W-1:0] data;   // b, g, r from high to low
    } wr_t;

endpackage

// ===== src/lt3d_ram.sv =====
module lt3d_ram #(
    parameter int DEPTH = 32768,
    parameter int AW    = 15,
    parameter int DW    = 54
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lt3d_axis_map.sv =====
module lt3d_axis_map #(
    parameter int MAX_EDGE  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [lt3d_pkg::IN_W-1:0]         c,
    input  logic [lt3d_pkg::VAL_W-1:0]        dmin,
    input  logic [lt3d_pkg::RECIP_W-1:0]      recip,
    input  logic [$clog2(MAX_EDGE+1)-1:0]     n,
    output logic [$clog2(MAX_EDGE)-1:0]       i0,
    output logic [$clog2(MAX_EDGE)-1:0]       i1,
    output logic [FRAC_BITS-1:0]              f
);

    localparam int NW = $clog2(MAX_EDGE + 1);
    localparam int CW = $clog2(MAX_EDGE);
    localparam int DW = lt3d_pkg::VAL_W + 1;
    localparam int PW = lt3d_pkg::PROD_W;
    localparam int TW = FRAC_BITS + 1;
    localparam int SW = TW + NW;

    logic signed [DW-1:0] diff_next, diff_reg;
    logic [PW-1:0]        prod_next, prod_reg;
    logic                 nonpos_reg;
    logic [TW-1:0]        t_next, t_reg;
    logic [SW-1:0]        pos_next;
    logic [NW-1:0]        i0p_next;
    logic [CW-1:0]        i0_next, i1_next, i0_reg, i1_reg;
    logic [FRAC_BITS-1:0] f_reg;

    // Stage 1: offset by domain minimum
    assign diff_next = $signed({3'b000, c}) - $signed({dmin[lt3d_pkg::VAL_W-1], dmin});

    // Stage 2: scale by reciprocal
    assign prod_next = PW'(diff_reg[DW-2:0]) * PW'(recip);

    // Stage 3: clamp to 0..1
    always_comb begin
        if (nonpos_reg) begin
            t_next = '0;
        end else if (|prod_reg[PW-1:32]) begin
            t_next = {1'b1, {FRAC_BITS{1'b0}}};
        end else begin
            t_next = {1'b0, prod_reg[31 -: FRAC_BITS]};
        end
    end

    // Stage 4: cell index and weight
    always_comb begin
        pos_next = SW'(t_reg) * SW'(n - NW'(1));
        i0_next  = CW'(pos_next >> FRAC_BITS);
        i0p_next = NW'(i0_next) + NW'(1);
        i1_next  = (i0p_next < n) ? CW'(i0p_next) : CW'(n - NW'(1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            diff_reg   <= diff_next;
            prod_reg   <= prod_next;
            nonpos_reg <= (diff_reg <= 0);
            t_reg      <= t_next;
            i0_reg     <= i0_next;
            i1_reg     <= i1_next;
            f_reg      <= pos_next[FRAC_BITS-1:0];
        end
    end

    assign i0 = i0_reg;
    assign i1 = i1_reg;
    assign f  = f_reg;

endmodule

// ===== src/lut3d_trilinear_sampler.sv =====
// Trilinear 3D colour table sampler. One word enters per clock on the s_axis
// side unless stalled: tuser low writes the table entry at the linear index in
// tdata (red fastest, then green, then blue), tuser high samples the RGB
// colour in tdata and produces one 8-bit-per-channel word on m_axis, in order.
// The pipeline holds one word per stage and sustains one word per clock
// while the skid slot is empty. The eight corners are read together from
// eight copies of the table, each with one write and one read port, so table
// writes take a pipeline slot like samples and land in order with them.
// Write lut_edge, domain minima and reciprocals through the cfg port only
// while the block is idle. Read only entries already written.
module lut3d_trilinear_sampler #(
    parameter int MAX_EDGE  = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // cfg: index of the register, data in the low bits
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [23:0]  cfg_data,
    // input stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // entry_index[14:0], entry_r[32:15], entry_g[50:33], entry_b[68:51],
    // in_r[84:69], in_g[100:85], in_b[116:101], zero pad[119:117]
    input  logic [119:0] s_axis_tdata,
    // op[0]
    input  logic         s_axis_tuser,
    // result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_r[7:0], out_g[15:8], out_b[23:16]
    output logic [23:0]  m_axis_tdata
);

    localparam int NW    = $clog2(MAX_EDGE + 1);
    localparam int CW    = $clog2(MAX_EDGE);
    localparam int STORE = MAX_EDGE * MAX_EDGE * MAX_EDGE;
    localparam int AW    = $clog2(STORE);
    localparam int IW    = (AW > lt3d_pkg::IDX_W) ? AW : lt3d_pkg::IDX_W;
    localparam int EW    = (NW > lt3d_pkg::EDGE_W) ? NW : lt3d_pkg::EDGE_W;
    localparam int VW    = lt3d_pkg::VAL_W;
    localparam int BPW   = FRAC_BITS + 20;
    localparam int NST   = 11;

    localparam logic signed [BPW-1:0] HALF =
        {{20{1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [lt3d_pkg::EDGE_W-1:0]  edge_reg;
    logic [VW-1:0]                min_reg   [3];
    logic [lt3d_pkg::RECIP_W-1:0] recip_reg [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= lt3d_pkg::EDGE_W'(32);
            for (int i = 0; i < 3; i++) begin
                min_reg[i]   <= '0;
                recip_reg[i] <= lt3d_pkg::RECIP_W'(65536);
            end
        end else if (cfg_valid) begin
            unique case (lt3d_pkg::cfg_idx_t'(cfg_index))
                lt3d_pkg::CFG_EDGE:    edge_reg     <= cfg_data[lt3d_pkg::EDGE_W-1:0];
                lt3d_pkg::CFG_MIN_R:   min_reg[0]   <= cfg_data[VW-1:0];
                lt3d_pkg::CFG_MIN_G:   min_reg[1]   <= cfg_data[VW-1:0];
                lt3d_pkg::CFG_MIN_B:   min_reg[2]   <= cfg_data[VW-1:0];
                lt3d_pkg::CFG_RECIP_R: recip_reg[0] <= cfg_data;
                lt3d_pkg::CFG_RECIP_G: recip_reg[1] <= cfg_data;
                lt3d_pkg::CFG_RECIP_B: recip_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective edge, clamped to 2..MAX_EDGE
    logic [EW-1:0] edge_ext;
    logic [NW-1:0] n;

    always_comb begin
        edge_ext = EW'(edge_reg);
        if (edge_ext < EW'(2)) begin
            n = NW'(2);
        end else if (edge_ext > EW'(MAX_EDGE)) begin
            n = NW'(MAX_EDGE);
        end else begin
            n = NW'(edge_ext);
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: whole pipe advances unless the skid slot is full
    // ---------------------------------------------------------------
    logic           en;
    logic           skid_v_reg;
    logic [NST:1]   v_reg;
    logic [NST:1]   op_reg;

    assign en            = !skid_v_reg;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[NST-1:1], s_axis_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg <= {op_reg[NST-1:1], s_axis_tuser};
        end
    end

    // ---------------------------------------------------------------
    // Stages 1-4: map each axis to cell index and weight
    // ---------------------------------------------------------------
    logic [lt3d_pkg::IN_W-1:0] col [3];
    logic [CW-1:0]             ax_i0 [3];
    logic [CW-1:0]             ax_i1 [3];
    logic [FRAC_BITS-1:0]      ax_f  [3];

    assign col[0] = s_axis_tdata[84:69];
    assign col[1] = s_axis_tdata[100:85];
    assign col[2] = s_axis_tdata[116:101];

    for (genvar a = 0; a < 3; a++) begin : g_axis
        lt3d_axis_map #(
            .MAX_EDGE (MAX_EDGE),
            .FRAC_BITS(FRAC_BITS)
        ) u_map (
            .aclk (aclk),
            .en   (en),
            .c    (col[a]),
            .dmin (min_reg[a]),
            .recip(recip_reg[a]),
            .n    (n),
            .i0   (ax_i0[a]),
            .i1   (ax_i1[a]),
            .f    (ax_f[a])
        );
    end

    // Table write rides along to the memory stage
    lt3d_pkg::wr_t wr_reg [1:6];

    always_ff @(posedge aclk) begin
        if (en) begin
            wr_reg[1].idx  <= s_axis_tdata[14:0];
            wr_reg[1].data <= {s_axis_tdata[68:51], s_axis_tdata[50:33], s_axis_tdata[32:15]};
            for (int s = 2; s <= 6; s++) begin
                wr_reg[s] <= wr_reg[s-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 5: z*n + y for the four (z, y) pairs
    // Stage 6: linear addresses of the eight corners
    // ---------------------------------------------------------------
    logic [AW-1:0]        zy_next [4];
    logic [AW-1:0]        zy_reg  [4];
    logic [CW-1:0]        x0_reg5, x1_reg5;
    logic [FRAC_BITS-1:0] fx_reg [5:7];
    logic [FRAC_BITS-1:0] fy_reg [5:8];
    logic [FRAC_BITS-1:0] fz_reg [5:9];
    logic [AW-1:0]        addr_next [8];
    logic [AW-1:0]        addr_reg  [8];

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            zy_next[j] = AW'(AW'(j[1] ? ax_i1[2] : ax_i0[2]) * AW'(n))
                       + AW'(j[0] ? ax_i1[1] : ax_i0[1]);
        end
        for (int k = 0; k < 8; k++) begin
            addr_next[k] = AW'(zy_reg[k >> 1] * AW'(n))
                         + AW'(k[0] ? x1_reg5 : x0_reg5);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zy_reg   <= zy_next;
            x0_reg5  <= ax_i0[0];
            x1_reg5  <= ax_i1[0];
            fx_reg[5] <= ax_f[0];
            fy_reg[5] <= ax_f[1];
            fz_reg[5] <= ax_f[2];
            addr_reg <= addr_next;
            for (int s = 6; s <= 7; s++) fx_reg[s] <= fx_reg[s-1];
            for (int s = 6; s <= 8; s++) fy_reg[s] <= fy_reg[s-1];
            for (int s = 6; s <= 9; s++) fz_reg[s] <= fz_reg[s-1];
        end
    end

    // ---------------------------------------------------------------
    // Stage 7: table access. Eight copies, each read at one corner;
    // every copy takes the same write.
    // ---------------------------------------------------------------
    logic [IW:0]                   widx;
    logic [IW-1:0]                 widx_ext;
    logic                          we;
    logic [lt3d_pkg::ENTRY_W-1:0]  rd [8];

    always_comb begin
        widx_ext = IW'(wr_reg[6].idx);
        widx     = {1'b0, widx_ext};
        we       = en && v_reg[6] && (op_reg[6] == lt3d_pkg::OP_WRITE)
                   && (widx < (IW+1)'(STORE));
    end

    for (genvar k = 0; k < 8; k++) begin : g_bank
        lt3d_ram #(
            .DEPTH(STORE),
            .AW   (AW),
            .DW   (lt3d_pkg::ENTRY_W)
        ) u_ram (
            .aclk (aclk),
            .we   (we),
            .waddr(widx_ext[AW-1:0]),
            .wdata(wr_reg[6].data),
            .re   (en),
            .raddr(addr_reg[k]),
            .rdata(rd[k])
        );
    end

    // Offset binary corner: flip the sign bit
    function automatic logic [VW-1:0] corner(input logic [lt3d_pkg::ENTRY_W-1:0] w,
                                             input int ch);
        logic [VW-1:0] raw;
        begin
            raw = w[ch*VW +: VW];
            corner = {~raw[VW-1], raw[VW-2:0]};
        end
    endfunction

    // a + round((b - a) * f), rounding half up
    function automatic logic [VW-1:0] blend(input logic [VW-1:0] a,
                                            input logic [VW-1:0] b,
                                            input logic [FRAC_BITS-1:0] f);
        logic signed [VW:0]    d;
        logic signed [BPW-1:0] p;
        logic signed [BPW-1:0] q;
        begin
            d = $signed({1'b0, b}) - $signed({1'b0, a});
            p = d * $signed({1'b0, f});
            q = (p + HALF) >>> FRAC_BITS;
            blend = a + q[VW-1:0];
        end
    endfunction

    // ---------------------------------------------------------------
    // Stages 8-10: blend along red, then green, then blue
    // ---------------------------------------------------------------
    logic [VW-1:0] cx_reg [3][4];
    logic [VW-1:0] cy_reg [3][2];
    logic [VW-1:0] cz_reg [3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                for (int j = 0; j < 4; j++) begin
                    cx_reg[ch][j] <= blend(corner(rd[2*j], ch), corner(rd[2*j+1], ch),
                                           fx_reg[7]);
                end
                for (int z = 0; z < 2; z++) begin
                    cy_reg[ch][z] <= blend(cx_reg[ch][2*z], cx_reg[ch][2*z+1], fy_reg[8]);
                end
                cz_reg[ch] <= blend(cy_reg[ch][0], cy_reg[ch][1], fz_reg[9]);
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 11: round to 8 bits and saturate
    // ---------------------------------------------------------------
    logic [23:0] pix_next, pix_reg;

    always_comb begin
        logic [VW-2:0] w;
        logic [25:0]   s;
        pix_next = '0;
        for (int ch = 0; ch < 3; ch++) begin
            w = cz_reg[ch][VW-2:0];
            s = 26'(w) * 26'(255) + 26'(32768);
            if (!cz_reg[ch][VW-1] || (w == '0)) begin
                pix_next[ch*8 +: 8] = '0;
            end else if (|s[25:24]) begin
                pix_next[ch*8 +: 8] = 8'hFF;
            end else begin
                pix_next[ch*8 +: 8] = s[23:16];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pix_reg <= pix_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register with one skid slot
    // ---------------------------------------------------------------
    logic        res_v;
    logic        out_v_reg;
    logic [23:0] out_d_reg, skid_d_reg;

    assign res_v = v_reg[NST] && (op_reg[NST] == lt3d_pkg::OP_SAMPLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_axis_tready || !out_v_reg) begin
            if (skid_v_reg) begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end else begin
                out_v_reg <= res_v;
            end
        end else if (res_v) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_axis_tready || !out_v_reg) begin
            out_d_reg <= skid_v_reg ? skid_d_reg : pix_reg;
        end else if (en) begin
            skid_d_reg <= pix_reg;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import lt3d_pkg::*;

    localparam int TBL_SIZE = 32768;
    localparam int CYCLE_LIMIT = 400000;
    // cfg index past the last register; the block must ignore it
    localparam logic [2:0] CFG_UNUSED = 3'd7;
    localparam int DRAIN_CYCLES = 20;   // time for the pipe to empty, plus margin
    localparam int FRAC_BITS_C = 16;

    typedef struct {
        op_t                      op;
        logic [IDX_W-1:0]         idx;
        logic signed [VAL_W-1:0]  er, eg, eb;
        logic [IN_W-1:0]          cr, cg, cb;
    } lut_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [23:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [119:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;

    always #10 aclk = ~aclk;

    lut3d_trilinear_sampler dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow of the block: table and registers as the predictor sees them
    logic [ENTRY_W-1:0]      lut_shadow [TBL_SIZE];
    bit                      lut_written [TBL_SIZE];
    logic [EDGE_W-1:0]       edge_shadow;
    logic signed [VAL_W-1:0] min_shadow [3];
    logic [RECIP_W-1:0]      recip_shadow [3];

    lut_word_t   word_q [$];      // words waiting for the driver
    logic [23:0] pixel_q [$];     // predicted pixels, oldest first

    int src_idle = 0;             // percent of cycles the sender idles
    int sink_stall = 0;           // percent of cycles the receiver stalls
    int hold_seq = 0;             // bump to request a long receiver hold-off
    int hold_seen = 0;
    int hold_left = 0;
    int err_cnt = 0;
    int n_samples = 0;
    int n_writes = 0;
    int n_pixels = 0;
    int cycles = 0;

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic int unsigned eff_edge;
        return (edge_shadow < 2) ? 2 : (edge_shadow > 32) ? 32 : int'(edge_shadow);
    endfunction

    // Map one channel onto its axis: lower cell index, upper index and weight.
    function automatic void map_channel(input logic [IN_W-1:0] c, input int ch,
                                        input int unsigned n, output int unsigned i0,
                                        output int unsigned i1,
                                        output longint unsigned w);
        longint diff;
        longint unsigned prod, t, pos;
        diff = longint'({1'b0, c}) - longint'(min_shadow[ch]);
        if (diff <= 0) begin
            t = 0;
        end else begin
            prod = longint'(diff) * longint'({1'b0, recip_shadow[ch]});
            t = (prod >= 64'h1_0000_0000) ? 64'h1_0000 : prod >> 16;
        end
        pos = t * (n - 1);
        i0 = int'(pos >> FRAC_BITS_C);
        w = pos & 64'hFFFF;
        i1 = (i0 + 1 < n) ? i0 + 1 : n - 1;
    endfunction

    // Table value of one channel, offset into 0..2^18-1
    function automatic longint unsigned entry_biased(input int unsigned x, y, z, n, ch);
        logic [VAL_W-1:0] v;
        v = lut_shadow[(z * n + y) * n + x][ch*VAL_W +: VAL_W];
        return longint'({~v[VAL_W-1], v[VAL_W-2:0]});
    endfunction

    function automatic longint unsigned lerp(input longint unsigned a, b, w);
        return (a * (64'h1_0000 - w) + b * w + 64'h8000) >> 16;
    endfunction

    function automatic logic [23:0] predict_pixel(input lut_word_t wd);
        int unsigned n, x0, x1, y0, y1, z0, z1;
        longint unsigned fx, fy, fz, c00, c10, c01, c11, c0, c1, v, o;
        logic [23:0] px;
        n = eff_edge();
        map_channel(wd.cr, 0, n, x0, x1, fx);
        map_channel(wd.cg, 1, n, y0, y1, fy);
        map_channel(wd.cb, 2, n, z0, z1, fz);
        for (int ch = 0; ch < 3; ch++) begin
            c00 = lerp(entry_biased(x0, y0, z0, n, ch), entry_biased(x1, y0, z0, n, ch), fx);
            c10 = lerp(entry_biased(x0, y1, z0, n, ch), entry_biased(x1, y1, z0, n, ch), fx);
            c01 = lerp(entry_biased(x0, y0, z1, n, ch), entry_biased(x1, y0, z1, n, ch), fx);
            c11 = lerp(entry_biased(x0, y1, z1, n, ch), entry_biased(x1, y1, z1, n, ch), fx);
            c0 = lerp(c00, c10, fy);
            c1 = lerp(c01, c11, fy);
            v = lerp(c0, c1, fz);
            if (v <= 64'h2_0000) begin
                o = 0;
            end else begin
                o = ((v - 64'h2_0000) * 255 + 32768) >> 16;
                if (o > 255) o = 255;
            end
            px[ch*8 +: 8] = o[7:0];
        end
        return px;
    endfunction

    // Queue a word for the driver and update the shadow / predictions in order.
    task automatic send_word(input lut_word_t wd);
        if (wd.op == OP_WRITE) begin
            lut_shadow[wd.idx] = {wd.eb, wd.eg, wd.er};
            lut_written[wd.idx] = 1'b1;
            n_writes++;
        end else begin
            pixel_q.push_back(predict_pixel(wd));
            n_samples++;
        end
        word_q.push_back(wd);
    endtask

    task automatic send_write(input int idx, input int r, g, b);
        lut_word_t wd;
        wd.op = OP_WRITE;
        wd.idx = IDX_W'(idx);
        wd.er = VAL_W'(r); wd.eg = VAL_W'(g); wd.eb = VAL_W'(b);
        wd.cr = IN_W'($urandom); wd.cg = IN_W'($urandom);   // ignored on a write
        wd.cb = IN_W'($urandom);
        send_word(wd);
    endtask

    // Write any corner the sample would read that was never written, then the sample.
    task automatic send_sample(input int r, g, b);
        lut_word_t wd;
        int unsigned n, cidx;
        int unsigned xs [2];
        int unsigned ys [2];
        int unsigned zs [2];
        longint unsigned fx, fy, fz;
        wd.op = OP_SAMPLE;
        wd.idx = IDX_W'($urandom);                              // ignored on a sample
        wd.er = VAL_W'($urandom); wd.eg = VAL_W'($urandom); wd.eb = VAL_W'($urandom);
        wd.cr = IN_W'(r); wd.cg = IN_W'(g); wd.cb = IN_W'(b);
        n = eff_edge();
        map_channel(wd.cr, 0, n, xs[0], xs[1], fx);
        map_channel(wd.cg, 1, n, ys[0], ys[1], fy);
        map_channel(wd.cb, 2, n, zs[0], zs[1], fz);
        for (int iz = 0; iz < 2; iz++)
            for (int iy = 0; iy < 2; iy++)
                for (int ix = 0; ix < 2; ix++) begin
                    cidx = (zs[iz] * n + ys[iy]) * n + xs[ix];
                    if (!lut_written[cidx])
                        send_write(int'(cidx), $urandom, $urandom, $urandom);
                end
        send_word(wd);
    endtask

    // Register write through the cfg channel; only called while idle.
    task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EDGE:    edge_shadow = val[EDGE_W-1:0];
            CFG_MIN_R:   min_shadow[0] = val[VAL_W-1:0];
            CFG_MIN_G:   min_shadow[1] = val[VAL_W-1:0];
            CFG_MIN_B:   min_shadow[2] = val[VAL_W-1:0];
            CFG_RECIP_R: recip_shadow[0] = val;
            CFG_RECIP_G: recip_shadow[1] = val;
            CFG_RECIP_B: recip_shadow[2] = val;
            default: ;
        endcase
    endtask

    task automatic set_domain(input int edge_n, input int mn, input int rc);
        write_reg(CFG_EDGE, 24'(edge_n));
        write_reg(CFG_MIN_R, 24'(mn));
        write_reg(CFG_MIN_G, 24'(mn));
        write_reg(CFG_MIN_B, 24'(mn));
        write_reg(CFG_RECIP_R, 24'(rc));
        write_reg(CFG_RECIP_G, 24'(rc));
        write_reg(CFG_RECIP_B, 24'(rc));
    endtask

    // Wait until every queued word went in and every pixel came out,
    // then let the last table write clear the pipe.
    task automatic drain;
        do @(posedge aclk);
        while (word_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic int rand_domain_min;
        case ($urandom_range(3))
            0: return -131072;
            1: return 131071;
            default: return int'($urandom_range(8192)) - 4096;
        endcase
    endfunction

    function automatic int rand_recip;
        case ($urandom_range(5))
            0: return 0;
            1: return 24'hFFFFFF;
            2: return int'($urandom_range(24'hFFFFFF));
            default: return int'($urandom_range(98304, 32768));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Driver: present the next word, hold it until accepted
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        lut_word_t wd;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (word_q.size() != 0 && $urandom_range(99) >= src_idle) begin
                wd = word_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser <= wd.op;
                s_axis_tdata <= {3'b000, wd.cb, wd.cg, wd.cr, wd.eb, wd.eg, wd.er, wd.idx};
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Long hold-off on the result side, counted here
    always @(posedge aclk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= 400;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        m_axis_tready <= aresetn && hold_left == 0 && $urandom_range(99) >= sink_stall;
    end

    // ---------------------------------------------------------------
    // Monitor: compare each pixel against the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        logic [23:0] want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_pixels++;
            if (pixel_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("ERROR: unexpected pixel %h", m_axis_tdata);
            end else begin
                want = pixel_q.pop_front();
                if (want !== m_axis_tdata) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("ERROR: pixel %0d r/g/b expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 n_pixels, want[7:0], want[15:8], want[23:16],
                                 m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16]);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    initial begin
        int mode;
        edge_shadow = EDGE_W'(32);
        for (int ch = 0; ch < 3; ch++) begin
            min_shadow[ch] = '0;
            recip_shadow[ch] = 24'd65536;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes at reset settings, then entries at the value limits
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h8000, 16'h0001, 16'hFFFE);
        send_write(0, -131072, -131072, -131072);
        send_write(TBL_SIZE - 1, 131071, 131071, 131071);
        send_write(1, 65536, 65535, 0);
        send_sample(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'h0400, 16'h0000, 16'h0000);
        drain();
        // Edge below range, zero reciprocal, unknown register index
        set_domain(0, 0, 0);
        write_reg(CFG_UNUSED, 24'hFFFFFF);
        send_sample(16'hFFFF, 16'h1234, 16'h0000);
        drain();
        set_domain(1, -131072, 24'hFFFFFF);
        send_sample(16'h0000, 16'hFFFF, 16'h7FFF);
        drain();
        set_domain(63, 131071, 24'hFFFFFF);      // colour always below minimum
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
        drain();
        set_domain(2, -65536, 32768);
        send_sample(16'hFFFF, 16'h0000, 16'h8000);
        send_sample(16'h0000, 16'hFFFF, 16'h4000);
        drain();

        // Random phases: each with its own settings and idling pattern
        for (int ph = 0; ph < 12; ph++) begin
            mode = ph % 4;
            src_idle = (mode == 1 || mode == 3) ? ((mode == 3) ? 22 : 51) : 0;
            sink_stall = (mode == 2 || mode == 3) ? ((mode == 3) ? 22 : 51) : 0;
            if (ph == 0)
                set_domain(32, 0, 65536);
            else if (ph == 4)
                set_domain(33, 0, 65536);
            else begin
                write_reg(CFG_EDGE, 24'($urandom_range(5)));
                for (int ch = 0; ch < 3; ch++) begin
                    write_reg(cfg_idx_t'(CFG_MIN_R + ch), 24'(rand_domain_min()));
                    write_reg(cfg_idx_t'(CFG_RECIP_R + ch), 24'(rand_recip()));
                end
            end
            if (ph == 8) hold_seq++;             // back up the pipe and stall the input
            for (int k = 0; k < 120; k++) begin
                if ($urandom_range(9) < 3)
                    send_write(($urandom_range(1) != 0) ? int'($urandom_range(124))
                                                        : int'($urandom_range(TBL_SIZE - 1)),
                               $urandom, $urandom, $urandom);
                else if (ph == 0 || ph == 4)     // full-size table: stay in a few cells
                    send_sample(int'($urandom_range(4095)), int'($urandom_range(4095)),
                                int'($urandom_range(4095)));
                else
                    send_sample($urandom, $urandom, $urandom);
            end
            drain();
        end

        $display("Covered %0d table writes and %0d samples, %0d pixels checked,",
                 n_writes, n_samples, n_pixels);
        $display("over edges 0..5, 32, 33 and 63, domain extremes, zero/max reciprocals"
                 , " and idle/stall mixes.");
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
src/lt3d_pkg.sv
src/lt3d_ram.sv
src/lt3d_axis_map.sv
src/lut3d_trilinear_sampler.sv
verif/tb.sv
